@@ src/sadt_pkg.sv @@
// Package for the salted address dedup table.
// Holds item and table entry types, function codes, the FSM state type and hash constants.
// Imported by salted_address_dedup_table and the testbench.
package sadt_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;

    localparam logic [31:0] FNV_BASIS  = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME  = 32'd16777619;
    localparam int          HASH_BYTES = 6;
    localparam int          BYTE_CNT_W = $clog2(HASH_BYTES);

    localparam logic [1:0] FUNC_OBSERVE = 2'd0;
    localparam logic [1:0] FUNC_SWEEP   = 2'd1;
    localparam logic [1:0] FUNC_CLEAR   = 2'd2;
    localparam logic [1:0] FUNC_UNUSED  = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [47:0] device_address;
        logic [31:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic [31:0] address_hash;
        logic        seen_before;
        logic        newly_inserted;
        logic        table_overflow;
        logic [31:0] gap_ms;
        logic [8:0]  distinct_count;
        logic        sweep_saturated;
    } t_out_item;

    typedef struct packed {
        logic [31:0] hash;
        logic [31:0] last_seen;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HASH,
        ST_SCAN,
        ST_EMIT
    } t_state;

endpackage

@@ src/sadt_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module sadt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/salted_address_dedup_table.sv @@
// Salted address dedup table, top level: hash unit, scan FSM, table RAM, output register.
// Observe hashes the address bytes, then scans the filled entries, then emits; other functions
// go straight to emit. One item at a time, paced by the single RAM read port
// during the linear scan. Output register lets the next item enter while a result waits.
// Reset (synchronous, active low) empties the table by clearing the fill count; no sweep.
// Depends on sadt_pkg and sadt_ram.
module salted_address_dedup_table
    import sadt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    t_state             r_state, n_state;
    logic [31:0]        r_salt;
    logic [CNT_W-1:0]   r_occ;
    logic               r_sat_now;
    logic               r_sat_latched;
    logic               r_out_vld;
    t_out_item          r_out;
    t_out_item          r_res;
    logic [31:0]        r_now_ms;
    logic [31:0]        r_hash;
    logic [47:0]        r_addr;
    logic [BYTE_CNT_W-1:0] r_byte;
    logic [CNT_W-1:0]   r_rd_idx;
    logic               r_pend;
    logic [IDX_W-1:0]   r_pend_idx;

    logic               in_acc;
    logic               out_load;
    logic               hash_last;
    logic [31:0]        hash_mix;
    logic [31:0]        hash_prod;
    logic               rd_en;
    logic               hit;
    logic               scan_done;
    logic               room;
    t_entry             ram_rdata;
    t_entry             ram_wdata;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [31:0]        gap;
    t_out_item          start_res;

    assign in_acc    = i_in_valid && !o_in_stall;
    assign out_load  = (r_state == ST_EMIT) && (!r_out_vld || !i_out_stall);
    assign hash_last = (r_byte == BYTE_CNT_W'(HASH_BYTES - 1));
    assign hash_mix  = r_hash ^ {24'd0, r_addr[7:0]};
    assign hash_prod = hash_mix * FNV_PRIME;
    assign rd_en     = (r_rd_idx < r_occ);
    assign hit       = r_pend && (ram_rdata.hash == r_hash);
    assign scan_done = hit || (!r_pend && !rd_en);
    assign room      = (r_occ < CNT_W'(TABLE_DEPTH));
    assign gap       = r_now_ms - ram_rdata.last_seen;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = (i_in_item.func == FUNC_OBSERVE) ? ST_HASH : ST_EMIT;
                end
            end
            ST_HASH: begin
                if (hash_last) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (scan_done) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_load) n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != ST_IDLE);
        ram_re     = (r_state == ST_SCAN) && !scan_done && rd_en;
        ram_raddr  = r_rd_idx[IDX_W-1:0];
        ram_we     = (r_state == ST_SCAN) && (hit || (scan_done && room));
        ram_waddr  = hit ? r_pend_idx : r_occ[IDX_W-1:0];
        ram_wdata.hash      = r_hash;
        ram_wdata.last_seen = r_now_ms;
        start_res  = '0;
        unique case (i_in_item.func)
            FUNC_SWEEP: begin
                start_res.distinct_count  = 9'(r_occ);
                start_res.sweep_saturated = r_sat_now;
            end
            FUNC_CLEAR: begin
                start_res.sweep_saturated = r_sat_latched;
            end
            default: begin
                start_res.distinct_count  = 9'(r_occ);
                start_res.sweep_saturated = r_sat_latched;
            end
        endcase
    end

    sadt_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_salt        <= '0;
            r_occ         <= '0;
            r_sat_now     <= 1'b0;
            r_sat_latched <= 1'b0;
            r_out_vld     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_salt <= i_cfg_data;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            if (in_acc) begin
                unique case (i_in_item.func)
                    FUNC_SWEEP: begin
                        r_sat_latched <= r_sat_now;
                        r_occ         <= '0;
                        r_sat_now     <= 1'b0;
                    end
                    FUNC_CLEAR: begin
                        r_occ     <= '0;
                        r_sat_now <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            if ((r_state == ST_SCAN) && scan_done && !hit) begin
                if (room) begin
                    r_occ <= r_occ + CNT_W'(1);
                end else begin
                    r_sat_now <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= r_res;
        end
        if (in_acc) begin
            r_now_ms <= i_in_item.now_ms;
            r_hash   <= FNV_BASIS ^ r_salt;
            r_addr   <= i_in_item.device_address;
            r_byte   <= '0;
            r_res    <= start_res;
        end
        if (r_state == ST_HASH) begin
            r_hash   <= hash_prod;
            r_addr   <= {8'd0, r_addr[47:8]};
            r_byte   <= r_byte + BYTE_CNT_W'(1);
            r_rd_idx <= '0;
            r_pend   <= 1'b0;
        end
        if (r_state == ST_SCAN) begin
            if (scan_done) begin
                r_res.address_hash    <= r_hash;
                r_res.seen_before     <= hit;
                r_res.newly_inserted  <= !hit && room;
                r_res.table_overflow  <= !hit && !room;
                r_res.gap_ms          <= hit ? gap : 32'd0;
                r_res.distinct_count  <= (!hit && room) ? 9'(r_occ + CNT_W'(1)) : 9'(r_occ);
                r_res.sweep_saturated <= r_sat_latched;
            end else begin
                if (rd_en) begin
                    r_rd_idx <= r_rd_idx + CNT_W'(1);
                end
                r_pend     <= rd_en;
                r_pend_idx <= r_rd_idx[IDX_W-1:0];
            end
        end
    end

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CNT_W'(TABLE_DEPTH))
        else $error("occupancy exceeds table depth");

    a_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == ST_SCAN) && scan_done)
        else $error("table write outside scan completion");

    a_one_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $countones({o_out_item.seen_before, o_out_item.newly_inserted,
                                    o_out_item.table_overflow}) <= 1)
        else $error("more than one observe outcome in result item");

    a_read_below_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_re |-> (r_rd_idx < r_occ))
        else $error("table read beyond fill count");

endmodule

@@ tb/tb_top.sv @@
// Self-checking bench for salted_address_dedup_table: hashed address lookups, sweeps, clears.
// A scoreboard class keeps a copy of the table and predicts every result; tasks drive items.
// Depends on sadt_pkg and the RTL under src.
module tb_top;
    import sadt_pkg::*;

    class dedup_scoreboard;
        logic [31:0] salt;
        logic        slot_used [TABLE_DEPTH];
        logic [31:0] slot_hash [TABLE_DEPTH];
        logic [31:0] slot_seen [TABLE_DEPTH];
        int unsigned fill;
        logic        sat_now;
        logic        sat_latched;
        t_out_item   expected_lookups[$];
        int unsigned errors;

        function new();
            salt        = '0;
            sat_latched = 1'b0;
            errors      = 0;
            wipe();
        endfunction

        function void wipe();
            int i;
            for (i = 0; i < TABLE_DEPTH; i++) begin
                slot_used[i] = 1'b0;
            end
            fill    = 0;
            sat_now = 1'b0;
        endfunction

        function logic [31:0] salted_hash(input logic [47:0] addr);
            logic [31:0] h;
            int b;
            h = FNV_BASIS ^ salt;
            for (b = 0; b < HASH_BYTES; b++) begin
                h = h ^ {24'd0, addr[8*b +: 8]};
                h = h * FNV_PRIME;
            end
            return h;
        endfunction

        function void note_item(input t_in_item it);
            t_out_item r;
            logic [31:0] h;
            int i;
            int hit;
            int free_idx;
            r = '0;
            case (it.func)
                FUNC_OBSERVE: begin
                    h = salted_hash(it.device_address);
                    r.address_hash = h;
                    hit = -1;
                    free_idx = -1;
                    for (i = 0; i < TABLE_DEPTH; i++) begin
                        if (slot_used[i] && slot_hash[i] == h) begin
                            hit = i;
                            break;
                        end
                        if (!slot_used[i] && free_idx < 0) free_idx = i;
                    end
                    if (hit >= 0) begin
                        r.seen_before = 1'b1;
                        r.gap_ms = it.now_ms - slot_seen[hit];
                        slot_seen[hit] = it.now_ms;
                    end else if (free_idx >= 0) begin
                        r.newly_inserted = 1'b1;
                        slot_used[free_idx] = 1'b1;
                        slot_hash[free_idx] = h;
                        slot_seen[free_idx] = it.now_ms;
                        fill++;
                    end else begin
                        r.table_overflow = 1'b1;
                        sat_now = 1'b1;
                    end
                    r.distinct_count = fill[8:0];
                end
                FUNC_SWEEP: begin
                    r.distinct_count = fill[8:0];
                    sat_latched = sat_now;
                    wipe();
                end
                FUNC_CLEAR: begin
                    wipe();
                    r.distinct_count = fill[8:0];
                end
                default: begin
                    r.distinct_count = fill[8:0];
                end
            endcase
            r.sweep_saturated = sat_latched;
            expected_lookups.push_back(r);
        endfunction

        function void compare_field(input string name, input logic [31:0] e, input logic [31:0] a);
            if (a !== e) begin
                $error("%s mismatch: expected 0x%08h, got 0x%08h", name, e, a);
                errors++;
            end
        endfunction

        function void check_item(input t_out_item got);
            t_out_item e;
            if (expected_lookups.size() == 0) begin
                $error("unexpected result item: 0x%0h", got);
                errors++;
                return;
            end
            e = expected_lookups.pop_front();
            compare_field("address_hash", e.address_hash, got.address_hash);
            compare_field("seen_before", 32'(e.seen_before), 32'(got.seen_before));
            compare_field("newly_inserted", 32'(e.newly_inserted), 32'(got.newly_inserted));
            compare_field("table_overflow", 32'(e.table_overflow), 32'(got.table_overflow));
            compare_field("gap_ms", e.gap_ms, got.gap_ms);
            compare_field("distinct_count", 32'(e.distinct_count), 32'(got.distinct_count));
            compare_field("sweep_saturated", 32'(e.sweep_saturated), 32'(got.sweep_saturated));
        endfunction

        function int pending();
            return expected_lookups.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_item = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_item;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data = '0;

    dedup_scoreboard sb;
    bit          tx_gaps = 1'b1;
    bit          rx_gaps = 1'b1;
    bit          hold_req = 1'b0;
    int unsigned items_sent = 0;
    logic [31:0] clock_ms = '0;
    logic [47:0] addr_pool [16];

    salted_address_dedup_table u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #30000000;
        $display("Verification failed");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_item(o_out_item);
    end

    initial begin : rx_stall_proc
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = 2500;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= rx_gaps && ($urandom_range(99) < 13);
            end
        end
    end

    function automatic t_in_item make_item(input logic [1:0] f, input logic [47:0] a,
                                           input logic [31:0] t);
        t_in_item it;
        it.func = f;
        it.device_address = a;
        it.now_ms = t;
        return it;
    endfunction

    function automatic logic [47:0] rand_addr();
        return 48'({$urandom, $urandom});
    endfunction

    function automatic logic [31:0] next_now();
        if ($urandom_range(9) == 0) clock_ms = $urandom;
        else clock_ms = clock_ms + $urandom_range(3000);
        return clock_ms;
    endfunction

    task automatic send_item(input t_in_item it);
        while (tx_gaps && $urandom_range(99) < 13) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_item(it);
        items_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_salt(input logic [31:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.salt = v;
    endtask

    task automatic run_sweep(input int sweep_no);
        int n;
        int i;
        int pick;
        bit fill_run;
        logic [47:0] a;
        for (i = 0; i < 16; i++) begin
            addr_pool[i] = rand_addr();
        end
        fill_run = (sweep_no < 2) || ($urandom_range(3) == 0);
        n = fill_run ? $urandom_range(300, 250) : $urandom_range(40, 1);
        for (i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            if (pick < 3) begin
                send_item(make_item(FUNC_UNUSED, rand_addr(), $urandom));
            end else if (pick < 5 && !fill_run) begin
                send_item(make_item(FUNC_CLEAR, rand_addr(), $urandom));
            end else begin
                if (fill_run) a = ($urandom_range(99) < 92) ? rand_addr()
                                                          : addr_pool[4'($urandom_range(15))];
                else a = ($urandom_range(99) < 70) ? addr_pool[4'($urandom_range(15))]
                                                  : rand_addr();
                send_item(make_item(FUNC_OBSERVE, a, next_now()));
            end
        end
        pick = (sweep_no == 1) ? 7 : $urandom_range(9);
        if (pick >= 9) send_item(make_item(FUNC_UNUSED, rand_addr(), $urandom));
        if (pick == 7 || pick == 8) send_item(make_item(FUNC_CLEAR, rand_addr(), $urandom));
        else send_item(make_item(FUNC_SWEEP, rand_addr(), $urandom));
    endtask

    initial begin : main_proc
        int sweep_no;
        logic [47:0] ones;
        sb = new();
        ones = 48'hFFFF_FFFF_FFFF;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_salt(32'h0000_0000);
        send_item(make_item(FUNC_OBSERVE, 48'd0, 32'd0));
        send_item(make_item(FUNC_OBSERVE, ones, 32'hFFFF_FFFF));
        send_item(make_item(FUNC_OBSERVE, 48'd0, 32'd7));
        send_item(make_item(FUNC_OBSERVE, ones, 32'd3));
        send_item(make_item(FUNC_UNUSED, ones, 32'hFFFF_FFFF));
        send_item(make_item(FUNC_SWEEP, 48'd0, 32'd0));
        send_item(make_item(FUNC_SWEEP, ones, 32'hFFFF_FFFF));
        send_item(make_item(FUNC_OBSERVE, 48'h0123_4567_89AB, 32'd100));
        send_item(make_item(FUNC_CLEAR, 48'd0, 32'd0));
        send_item(make_item(FUNC_OBSERVE, 48'h0123_4567_89AB, 32'd200));
        send_item(make_item(FUNC_CLEAR, ones, 32'hFFFF_FFFF));
        drain();

        write_salt(32'hFFFF_FFFF);
        send_item(make_item(FUNC_OBSERVE, 48'd0, 32'd0));
        send_item(make_item(FUNC_OBSERVE, 48'd0, 32'd0));
        send_item(make_item(FUNC_OBSERVE, ones, 32'h8000_0000));
        send_item(make_item(FUNC_SWEEP, 48'd0, 32'd0));
        drain();

        sweep_no = 0;
        while (items_sent < 1600) begin
            if (sweep_no % 4 == 3) begin
                drain();
                case ($urandom_range(3))
                    0: write_salt(32'h0000_0000);
                    1: write_salt(32'hFFFF_FFFF);
                    default: write_salt($urandom);
                endcase
            end
            if (sweep_no == 2) hold_req = 1'b1;
            tx_gaps = !(sweep_no >= 5 && sweep_no <= 8);
            rx_gaps = tx_gaps;
            run_sweep(sweep_no);
            sweep_no++;
        end

        drain();
        repeat (300) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
